[rtl/pdd_pkg.sv]
// Package with the phase type, constants and base lookup for the packed DNA decoder.
package pdd_pkg;

  // Decoder phases; codes above PH_NRUN are never produced.
  typedef enum logic [2:0] {
    PH_REC_LEN = 3'd0,
    PH_BLK_LEN = 3'd1,
    PH_WORDS   = 3'd2,
    PH_FLAG    = 3'd3,
    PH_NRUN    = 3'd4
  } phase_e;

  localparam int unsigned BasesPerWord = 32;
  localparam logic [6:0]  NrunFull     = 7'd127;
  localparam logic [7:0]  CharN        = 8'h4E;
  localparam logic [7:0]  CharMarker   = 8'h00;
  localparam logic [1:0]  CodeMask     = 2'd3;

  // Map a 2-bit base code to its ASCII letter.
  function automatic logic [7:0] base_of_code(input logic [1:0] code);
    logic [7:0] ch;
    case (code & CodeMask)
      2'd0:    ch = 8'h41;
      2'd1:    ch = 8'h43;
      2'd2:    ch = 8'h47;
      default: ch = 8'h54;
    endcase
    return ch;
  endfunction

endpackage

[rtl/pdd_in_if.sv]
// Input byte channel of the packed DNA decoder.
interface pdd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink (input valid, input byte_in, output ready);
endinterface

[rtl/pdd_out_if.sv]
// Result channel of the packed DNA decoder.
interface pdd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] base_char;
  logic [6:0] repeat_count;
  logic       last_of_item;
  logic       record_end;
  logic       length_error;

  modport source (output valid, output base_char, output repeat_count, output last_of_item,
                  output record_end, output length_error, input ready);
  modport sink (input valid, input base_char, input repeat_count, input last_of_item,
                input record_end, input length_error, output ready);
endinterface

[rtl/packed_dna_block_stream_decoder.sv]
// Top level of the packed DNA block stream decoder.
//
//   channel | direction | carries
//   --------+-----------+----------------------------------------------------
//   in_i    | sink      | byte_in: one byte of the compressed record
//   out_o   | source    | base_char, repeat_count, last_of_item, record_end,
//           |           | length_error: one run of bases per transfer
//
// A byte is decoded in the cycle it is accepted; its results are loaded into a
// result register that emits one result per cycle while the output is ready, so
// a full word gives 32 results on the output and eight bytes feed it.
// Bytes that cause no result are accepted every cycle even while results drain.
// A byte that causes results waits only until the last pending result is taken.
// Reset (rst_ni low, asynchronous) returns to awaiting the record length.
module packed_dna_block_stream_decoder
  import pdd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  pdd_in_if.sink    in_i,
  pdd_out_if.source out_o
);

  // Decoder state.
  phase_e      phase_q, phase_d;
  logic [2:0]  idx_q, idx_d;
  logic [63:0] word_q, word_d;
  logic [63:0] total_q, total_d;
  logic [63:0] done_q, done_d;
  logic [63:0] left_q, left_d;

  // Pending results of one byte.
  logic        jvalid_q, jvalid_d;
  logic [63:0] jword_q, jword_d;
  logic [5:0]  jcnt_q, jcnt_d;
  logic        jbase_q, jbase_d;
  logic [7:0]  jchar_q, jchar_d;
  logic [6:0]  jrep_q, jrep_d;
  logic        jend_q, jend_d;
  logic        jerr_q, jerr_d;

  // Decode results for the byte at the input.
  logic        emit;
  logic [63:0] ld_word;
  logic [5:0]  ld_cnt;
  logic        ld_base;
  logic [7:0]  ld_char;
  logic [6:0]  ld_rep;
  logic        ld_end;
  logic        ld_err;

  logic        in_fire, out_fire, out_last;

  // Byte decode and state update.
  always_comb begin
    logic [63:0] asm_w;
    logic        full;
    logic [63:0] addend;
    logic [64:0] sum;
    logic [63:0] done_sat;
    logic [5:0]  n;
    logic [5:0]  pad;
    phase_d  = phase_q;
    idx_d    = idx_q;
    word_d   = word_q;
    total_d  = total_q;
    done_d   = done_q;
    left_d   = left_q;
    emit     = 1'b0;
    ld_word  = '0;
    ld_cnt   = 6'd1;
    ld_base  = 1'b0;
    ld_char  = CharMarker;
    ld_rep   = '0;
    ld_end   = 1'b0;
    ld_err   = 1'b0;
    asm_w    = word_q | ({56'd0, in_i.byte_in} << {idx_q, 3'b000});
    full     = (idx_q == 3'd7);
    addend   = (phase_q == PH_BLK_LEN) ? asm_w
             : (in_i.byte_in[7] ? {57'd0, in_i.byte_in[6:0]} : {57'd0, NrunFull});
    sum      = {1'b0, done_q} + {1'b0, addend};
    done_sat = sum[64] ? '1 : sum[63:0];
    n        = (left_q >= 64'(BasesPerWord)) ? 6'(BasesPerWord) : left_q[5:0];
    pad      = 6'(BasesPerWord) - n;
    case (phase_q)
      PH_BLK_LEN: begin
        idx_d  = idx_q + 3'd1;
        word_d = full ? '0 : asm_w;
        if (full) begin
          left_d  = asm_w;
          done_d  = done_sat;
          phase_d = (asm_w != '0) ? PH_WORDS : PH_FLAG;
        end
      end
      PH_WORDS: begin
        idx_d  = idx_q + 3'd1;
        word_d = full ? '0 : asm_w;
        if (full) begin
          emit    = 1'b1;
          ld_base = 1'b1;
          ld_cnt  = n;
          ld_word = asm_w << {pad[4:0], 1'b0};
          left_d  = left_q - {58'd0, n};
          if (left_q == {58'd0, n}) begin
            phase_d = PH_FLAG;
          end
        end
      end
      PH_FLAG: begin
        if (in_i.byte_in != 8'd0) begin
          phase_d = PH_NRUN;
        end else if (done_q >= total_q) begin
          emit    = 1'b1;
          ld_end  = 1'b1;
          ld_err  = (done_q > total_q);
          phase_d = PH_REC_LEN;
          done_d  = '0;
        end else begin
          phase_d = PH_BLK_LEN;
        end
      end
      PH_NRUN: begin
        emit    = 1'b1;
        ld_char = CharN;
        ld_rep  = addend[6:0];
        done_d  = done_sat;
        if (in_i.byte_in[7]) begin
          if (done_sat >= total_q) begin
            ld_end  = 1'b1;
            ld_err  = (done_sat > total_q);
            phase_d = PH_REC_LEN;
            done_d  = '0;
          end else begin
            phase_d = PH_BLK_LEN;
          end
        end
      end
      default: begin
        // Awaiting the record length.
        idx_d  = idx_q + 3'd1;
        word_d = full ? '0 : asm_w;
        if (full) begin
          total_d = asm_w;
          done_d  = '0;
          if (asm_w == '0) begin
            emit    = 1'b1;
            ld_end  = 1'b1;
            phase_d = PH_REC_LEN;
          end else begin
            phase_d = PH_BLK_LEN;
          end
        end
      end
    endcase
  end

  // Handshakes: a byte with results waits for the pending results to drain.
  assign out_last  = (jcnt_q == 6'd1);
  assign out_fire  = jvalid_q && out_o.ready;
  assign in_i.ready = !jvalid_q || (out_fire && out_last) || !emit;
  assign in_fire   = in_i.valid && in_i.ready;

  // Result register: load on a byte with results, shift out one per transfer.
  always_comb begin
    jvalid_d = jvalid_q;
    jword_d  = jword_q;
    jcnt_d   = jcnt_q;
    jbase_d  = jbase_q;
    jchar_d  = jchar_q;
    jrep_d   = jrep_q;
    jend_d   = jend_q;
    jerr_d   = jerr_q;
    if (out_fire) begin
      jvalid_d = !out_last;
      jcnt_d   = jcnt_q - 6'd1;
      jword_d  = jword_q << 2;
    end
    if (in_fire && emit) begin
      jvalid_d = 1'b1;
      jword_d  = ld_word;
      jcnt_d   = ld_cnt;
      jbase_d  = ld_base;
      jchar_d  = ld_char;
      jrep_d   = ld_rep;
      jend_d   = ld_end;
      jerr_d   = ld_err;
    end
  end

  // Decoder state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_REC_LEN;
      idx_q    <= '0;
      word_q   <= '0;
      total_q  <= '0;
      done_q   <= '0;
      left_q   <= '0;
      jvalid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        phase_q <= phase_d;
        idx_q   <= idx_d;
        word_q  <= word_d;
        total_q <= total_d;
        done_q  <= done_d;
        left_q  <= left_d;
      end
      jvalid_q <= jvalid_d;
    end
  end

  // Result payload registers.
  always_ff @(posedge clk_i) begin
    jword_q <= jword_d;
    jcnt_q  <= jcnt_d;
    jbase_q <= jbase_d;
    jchar_q <= jchar_d;
    jrep_q  <= jrep_d;
    jend_q  <= jend_d;
    jerr_q  <= jerr_d;
  end

  // Output fields.
  assign out_o.valid        = jvalid_q;
  assign out_o.base_char    = jbase_q ? base_of_code(jword_q[63:62]) : jchar_q;
  assign out_o.repeat_count = jbase_q ? 7'd1 : jrep_q;
  assign out_o.last_of_item = out_last;
  assign out_o.record_end   = out_last && jend_q;
  assign out_o.length_error = out_last && jerr_q;

endmodule

[rtl/pdd_checker.sv]
// Port-level checks for the packed DNA decoder, bound to the top level.
module pdd_checker
  import pdd_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] base_char_i,
  input logic [6:0] repeat_count_i,
  input logic       last_of_item_i,
  input logic       record_end_i,
  input logic       length_error_i
);

  // The record end is flagged only on the last result of a byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && record_end_i |-> last_of_item_i)
    else $error("record_end without last_of_item");

  // A length error is reported only where the record ends.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && length_error_i |-> record_end_i)
    else $error("length_error without record_end");

  // A marker result has no copies and always closes a record.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && base_char_i == CharMarker |-> record_end_i && repeat_count_i == 7'd0)
    else $error("marker result malformed");

  // A stalled result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result withdrawn while stalled");

endmodule

bind packed_dna_block_stream_decoder pdd_checker u_pdd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .base_char_i    (out_o.base_char),
  .repeat_count_i (out_o.repeat_count),
  .last_of_item_i (out_o.last_of_item),
  .record_end_i   (out_o.record_end),
  .length_error_i (out_o.length_error)
);

[tb/sv/packed_dna_block_stream_decoder_tb.sv]
// Self-checking testbench for the packed DNA block stream decoder.
module packed_dna_block_stream_decoder_tb;
  import pdd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 300000;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned TargetBytes = 220;
  localparam int unsigned SettleCycles = 50;
  localparam int unsigned MaxPrinted = 40;

  // One decoded run as seen on the result channel.
  typedef struct packed {
    logic [7:0] base_char;
    logic [6:0] repeat_count;
    logic       last_of_item;
    logic       record_end;
    logic       length_error;
  } run_t;

  // Tracks the decoder state and holds the runs that are still owed.
  class dna_run_scoreboard;
    phase_e      phase;
    logic [2:0]  byte_idx;
    logic [63:0] word_acc;
    logic [63:0] rec_total;
    logic [63:0] bases_done;
    logic [63:0] blk_left;
    run_t        expected_runs[$];
    run_t        byte_runs[$];
    string       letters;
    int unsigned errors;

    function new();
      phase      = PH_REC_LEN;
      byte_idx   = '0;
      word_acc   = '0;
      rec_total  = '0;
      bases_done = '0;
      blk_left   = '0;
      letters    = "ACGT";
      errors     = 0;
    endfunction

    task report(input string msg);
      if (errors < MaxPrinted) begin
        $display("[%0t] ERROR: %s", $realtime, msg);
      end
      errors++;
    endtask

    // Running base count saturates instead of wrapping.
    function void add_bases(input logic [63:0] v);
      logic [64:0] sum;
      sum = {1'b0, bases_done} + {1'b0, v};
      bases_done = sum[64] ? '1 : sum[63:0];
    endfunction

    function void emit(input logic [7:0] ch, input logic [6:0] rep);
      run_t r;
      r = '0;
      r.base_char = ch;
      r.repeat_count = rep;
      byte_runs.push_back(r);
    endfunction

    // At a block end, close the record once the count is reached or when forced.
    function void close_record(input bit force_end);
      int last;
      if (force_end || bases_done >= rec_total) begin
        if (byte_runs.size() == 0) begin
          emit(CharMarker, 7'd0);
        end
        last = byte_runs.size() - 1;
        byte_runs[last].record_end = 1'b1;
        byte_runs[last].length_error = (bases_done > rec_total);
        phase = PH_REC_LEN;
        bases_done = '0;
      end else begin
        phase = PH_BLK_LEN;
      end
    endfunction

    // Decode one accepted byte and queue the runs it must cause.
    function void decode_byte(input logic [7:0] b);
      bit full;
      int n;
      int sh;
      byte_runs.delete();
      case (phase)
        PH_REC_LEN, PH_BLK_LEN, PH_WORDS: begin
          word_acc = word_acc | (64'(b) << (8 * byte_idx));
          full = (byte_idx == 3'd7);
          byte_idx = byte_idx + 3'd1;
          if (full) begin
            if (phase == PH_REC_LEN) begin
              rec_total = word_acc;
              bases_done = '0;
              word_acc = '0;
              if (rec_total == 0) begin
                close_record(1'b1);
              end else begin
                phase = PH_BLK_LEN;
              end
            end else if (phase == PH_BLK_LEN) begin
              blk_left = word_acc;
              word_acc = '0;
              add_bases(blk_left);
              phase = (blk_left != 0) ? PH_WORDS : PH_FLAG;
            end else begin
              n = (blk_left >= 64'd32) ? 32 : int'(blk_left);
              for (int i = 0; i < n; i++) begin
                sh = 2 * (n - 1 - i);
                emit(8'(letters[int'(word_acc[sh +: 2])]), 7'd1);
              end
              blk_left = blk_left - 64'(n);
              word_acc = '0;
              if (blk_left == 0) begin
                phase = PH_FLAG;
              end
            end
          end
        end
        PH_FLAG: begin
          if (b != 8'd0) begin
            phase = PH_NRUN;
          end else begin
            close_record(1'b0);
          end
        end
        default: begin
          // N-run bytes: a clear top bit adds a full run, a set one terminates.
          if (!b[7]) begin
            add_bases(64'(NrunFull));
            emit(CharN, NrunFull);
          end else begin
            add_bases(64'(b[6:0]));
            emit(CharN, b[6:0]);
            close_record(1'b0);
          end
        end
      endcase
      if (byte_runs.size() > 0) begin
        byte_runs[byte_runs.size() - 1].last_of_item = 1'b1;
      end
      foreach (byte_runs[i]) begin
        expected_runs.push_back(byte_runs[i]);
      end
    endfunction

    // Compare one transferred run against the oldest one owed.
    task check_run(input run_t got);
      run_t want;
      if (expected_runs.size() == 0) begin
        report($sformatf("unexpected run base=%h rep=%0d last=%b end=%b err=%b",
                         got.base_char, got.repeat_count, got.last_of_item,
                         got.record_end, got.length_error));
      end else begin
        want = expected_runs.pop_front();
        if (got !== want) begin
          report($sformatf({"run mismatch: got base=%h rep=%0d last=%b end=%b err=%b, ",
                            "want base=%h rep=%0d last=%b end=%b err=%b"},
                           got.base_char, got.repeat_count, got.last_of_item,
                           got.record_end, got.length_error, want.base_char,
                           want.repeat_count, want.last_of_item, want.record_end,
                           want.length_error));
        end
      end
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  bit hold_req = 1'b0;
  int unsigned cycles = 0;
  logic [7:0] stim[$];
  dna_run_scoreboard sb;
  run_t got_run;

  pdd_in_if in_if ();
  pdd_out_if out_if ();

  packed_dna_block_stream_decoder uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // Free-running 10 ns clock.
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Check every run transferred out of the block.
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      got_run = {out_if.base_char, out_if.repeat_count, out_if.last_of_item,
                 out_if.record_end, out_if.length_error};
      sb.check_run(got_run);
    end
  end

  // Result side: random stall patterns that change from span to span, plus
  // one long hold-off on request.
  initial begin : result_sink
    int mode;
    int span;
    int tick;
    tick = 0;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      mode = $urandom_range(0, 4);
      span = $urandom_range(40, 200);
      repeat (span) begin
        @(negedge clk_i);
        if (hold_req) begin
          out_if.ready = 1'b0;
          repeat (HoldCycles) @(negedge clk_i);
          hold_req = 1'b0;
        end
        tick++;
        case (mode)
          1: out_if.ready = 1'($urandom_range(0, 1));
          2: out_if.ready = (tick % 4 == 0);
          3: out_if.ready = ($urandom_range(0, 9) != 0);
          default: out_if.ready = 1'b1;
        endcase
      end
    end
  end

  function automatic void push_u64(ref logic [7:0] q[$], input logic [63:0] v);
    for (int i = 0; i < 8; i++) begin
      q.push_back(v[8*i +: 8]);
    end
  endfunction

  // Build one record of random blocks, or an empty one; the record count is exact,
  // short of the block bases (overshoot), or beyond them so that the record stays open.
  function automatic void gen_record(input bit open_ended);
    logic [7:0] body[$];
    int unsigned ends[$];
    logic [63:0] cums[$];
    logic [63:0] cum;
    logic [63:0] total;
    logic [63:0] blk;
    logic [7:0] term;
    int pick;
    int kind;
    int nfull;
    int stop;
    cum = '0;
    pick = $urandom_range(0, 99);
    if (pick < 6) begin
      push_u64(stim, 64'd0);
      return;
    end
    for (int b = 0; b < $urandom_range(1, 3); b++) begin
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        blk = 64'd0;
      end else if (kind < 6) begin
        blk = 64'($urandom_range(1, 31));
      end else if (kind == 6) begin
        blk = 64'd32;
      end else begin
        blk = 64'($urandom_range(33, 100));
      end
      push_u64(body, blk);
      repeat ((blk + 31) / 32) begin
        repeat (8) body.push_back(8'($urandom_range(0, 255)));
      end
      cum = cum + blk;
      if ($urandom_range(0, 9) < 4) begin
        body.push_back(8'h00);
      end else begin
        body.push_back(8'($urandom_range(1, 255)));
        nfull = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
        repeat (nfull) body.push_back(8'($urandom_range(0, 127)));
        term = ($urandom_range(0, 4) == 0) ? 8'h80 : 8'($urandom_range(128, 255));
        body.push_back(term);
        cum = cum + 64'(127 * nfull) + 64'(term[6:0]);
      end
      ends.push_back(body.size());
      cums.push_back(cum);
    end
    if (cum == 0) begin
      push_u64(stim, 64'd0);
      return;
    end
    total = cum;
    if (open_ended) begin
      total = cum + 64'($urandom_range(1, 50));
    end else if (pick >= 80 && cum >= 2) begin
      total = 64'($urandom_range(1, int'(cum) - 1));
    end
    // The record closes at the first block that reaches the count.
    stop = body.size();
    for (int i = cums.size() - 1; i >= 0; i--) begin
      if (cums[i] >= total) begin
        stop = ends[i];
      end
    end
    push_u64(stim, total);
    for (int i = 0; i < stop; i++) begin
      stim.push_back(body[i]);
    end
  endfunction

  // Offer one byte and wait for its transfer.
  task automatic send_byte(input logic [7:0] b);
    @(negedge clk_i);
    in_if.valid = 1'b1;
    in_if.byte_in = b;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    sb.decode_byte(b);
  endtask

  task automatic idle_input(input int n);
    repeat (n) begin
      @(negedge clk_i);
      in_if.valid = 1'b0;
      in_if.byte_in = 8'($urandom_range(0, 255));
    end
  endtask

  // Hold the input quiet until every owed run has come out.
  task automatic drain_results();
    idle_input(1);
    while (sb.expected_runs.size() != 0) @(posedge clk_i);
  endtask

  // Reset, stimulus and final verdict.
  initial begin : stimulus
    int idx;
    int burst;
    int gap;
    int directed_len;
    int hold_at;
    int drain_at;
    sb = new();
    in_if.valid = 1'b0;
    in_if.byte_in = 8'h00;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: an empty record, then five bases, a full N byte and a
    // zero-length N terminator that closes the record exactly.
    push_u64(stim, 64'd0);
    push_u64(stim, 64'd132);
    push_u64(stim, 64'd5);
    push_u64(stim, 64'hFFFF_FFFF_FFFF_FC6F);
    stim.push_back(8'hFF);
    stim.push_back(8'h00);
    stim.push_back(8'h80);
    directed_len = stim.size();

    // Random records, one left open, then a tail of raw bytes.
    while (stim.size() < TargetBytes) gen_record(1'b0);
    gen_record(1'b1);
    repeat (16) stim.push_back(8'($urandom_range(0, 255)));
    hold_at = stim.size() / 3;
    drain_at = 2 * stim.size() / 3;

    idx = 0;
    while (idx < stim.size()) begin
      burst = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      for (int i = 0; i < burst && idx < stim.size(); i++) begin
        if (idx == directed_len || idx == drain_at) begin
          drain_results();
        end
        if (idx == hold_at) begin
          hold_req = 1'b1;
        end
        send_byte(stim[idx]);
        idx++;
      end
      idle_input(gap);
    end

    drain_results();
    repeat (SettleCycles) @(posedge clk_i);
    while (sb.expected_runs.size() != 0) begin
      sb.report("expected run never transferred");
      void'(sb.expected_runs.pop_front());
    end
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/pdd_pkg.sv
rtl/pdd_in_if.sv
rtl/pdd_out_if.sv
rtl/packed_dna_block_stream_decoder.sv
rtl/pdd_checker.sv
tb/sv/packed_dna_block_stream_decoder_tb.sv
